[sv/online_bin_packer_top_assert.svh]
// Assertion macros for the online bin packer top level.
// Depends on nothing; included by online_bin_packer_top.sv.
`ifndef ONLINE_BIN_PACKER_TOP_ASSERT_SVH
`define ONLINE_BIN_PACKER_TOP_ASSERT_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define OBP_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define OBP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/obp_pkg.sv]
// Shared types and codes for the online bin packer.
// No dependencies; imported by obp_ctrl, obp_dp and online_bin_packer_top.
`timescale 1ns / 1ps

package obp_pkg;

    // Result status codes
    localparam logic [1:0] ST_PLACED = 2'd0;
    localparam logic [1:0] ST_HEAVY  = 2'd1;
    localparam logic [1:0] ST_FULL   = 2'd2;

    // Register indexes (address bit 2)
    localparam logic REG_CAP  = 1'b0;
    localparam logic REG_MODE = 1'b1;

    localparam logic [15:0] CAP_RESET = 16'd100;
    localparam logic        FIT_FIRST = 1'b0;

    typedef struct packed {
        logic load;     // latch the accepted item, restart the scan
        logic rd_en;    // read the next open bin
        logic commit;   // place the item and load the result register
    } obp_cmd_t;

    typedef struct packed {
        logic heavy;      // item exceeds capacity
        logic ff_hit;     // first fit found its bin this cycle
        logic scan_end;   // every open bin compared
        logic can_issue;  // unread open bins remain
        logic out_free;   // result register can take a result
    } obp_sts_t;

endpackage

[sv/obp_ctrl.sv]
// Controller state machine for the online bin packer.
// Depends on obp_pkg; drives obp_dp through obp_cmd_t and reads obp_sts_t.
`timescale 1ns / 1ps

module obp_ctrl
    import obp_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_tvalid,
    output logic     s_tready,
    input  obp_sts_t sts,
    output obp_cmd_t cmd
);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SCAN   = 2'd1;
    localparam logic [1:0] S_COMMIT = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       scan_done;

    assign scan_done = sts.heavy || sts.ff_hit || sts.scan_end;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                s_tready = 1'b1;
                cmd.load = s_tvalid;
                if (s_tvalid) begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN: begin
                cmd.rd_en = !scan_done && sts.can_issue;
                if (scan_done) begin
                    state_next = S_COMMIT;
                end
            end
            S_COMMIT: begin
                // hold until the result register is free
                if (sts.out_free) begin
                    cmd.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

[sv/obp_dp.sv]
// Datapath for the online bin packer: residual memory, scan compare, result register.
// Depends on obp_pkg; commanded by obp_ctrl.
`timescale 1ns / 1ps

module obp_dp
    import obp_pkg::*;
#(
    parameter int MAX_BINS    = 64,
    parameter int WEIGHT_BITS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  obp_cmd_t    cmd,
    output obp_sts_t    sts,
    input  logic [15:0] s_item_weight,
    input  logic        s_last,
    input  logic [15:0] cfg_cap,
    input  logic        cfg_mode,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata
);

    localparam int IDX_W = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
    localparam int CNT_W = $clog2(MAX_BINS + 1);
    localparam int WB    = WEIGHT_BITS;

    logic [WB-1:0]    mem [MAX_BINS];

    logic [WB-1:0]    w_reg;
    logic [WB-1:0]    cap_reg;
    logic             mode_reg;
    logic             last_reg;
    logic             heavy_reg;
    logic [CNT_W-1:0] open_reg;
    logic [CNT_W-1:0] open_next;
    logic [CNT_W-1:0] issue_reg;
    logic             chk_v_reg;
    logic [IDX_W-1:0] chk_idx_reg;
    logic [WB-1:0]    rdata_reg;
    logic             found_reg;
    logic [IDX_W-1:0] best_idx_reg;
    logic [WB-1:0]    best_left_reg;
    logic             out_valid_reg;
    logic [15:0]      out_data_reg;

    logic [31:0]      w32;
    logic [31:0]      cap32;
    logic [WB-1:0]    w_in;
    logic [WB-1:0]    cap_in;
    logic             fits;
    logic [WB-1:0]    left;
    logic             better;

    logic [1:0]       res_status;
    logic [IDX_W-1:0] res_idx;
    logic             res_opened;
    logic [CNT_W-1:0] n_after;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    logic [WB-1:0]    wr_data;
    logic [31:0]      idx32;
    logic [31:0]      n32;

    // take fields modulo 2^WEIGHT_BITS
    assign w32    = 32'(s_item_weight);
    assign cap32  = 32'(cfg_cap);
    assign w_in   = w32[WB-1:0];
    assign cap_in = cap32[WB-1:0];

    assign fits   = rdata_reg >= w_reg;
    assign left   = rdata_reg - w_reg;
    assign better = chk_v_reg && fits && (!found_reg || left < best_left_reg);

    assign sts.heavy     = heavy_reg;
    assign sts.ff_hit    = chk_v_reg && fits && (mode_reg == FIT_FIRST);
    assign sts.scan_end  = (issue_reg == open_reg) && !chk_v_reg;
    assign sts.can_issue = issue_reg < open_reg;
    assign sts.out_free  = !out_valid_reg || m_tready;

    // placement decision after the scan
    always_comb begin
        res_status = ST_PLACED;
        res_idx    = '0;
        res_opened = 1'b0;
        n_after    = open_reg;
        wr_en      = 1'b0;
        wr_addr    = best_idx_reg;
        wr_data    = best_left_reg;
        if (heavy_reg) begin
            res_status = ST_HEAVY;
        end else if (found_reg) begin
            res_idx = best_idx_reg;
            wr_en   = 1'b1;
        end else if (open_reg < CNT_W'(MAX_BINS)) begin
            res_idx    = open_reg[IDX_W-1:0];
            res_opened = 1'b1;
            n_after    = open_reg + CNT_W'(1);
            wr_en      = 1'b1;
            wr_addr    = open_reg[IDX_W-1:0];
            wr_data    = cap_reg - w_reg;
        end else begin
            res_status = ST_FULL;
        end
    end

    assign idx32     = 32'(res_idx);
    assign n32       = 32'(n_after);
    assign open_next = last_reg ? '0 : n_after;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            open_reg      <= '0;
            issue_reg     <= '0;
            chk_v_reg     <= 1'b0;
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cmd.load) begin
                issue_reg <= '0;
                chk_v_reg <= 1'b0;
                found_reg <= 1'b0;
            end else begin
                chk_v_reg <= cmd.rd_en;
                if (cmd.rd_en) begin
                    issue_reg <= issue_reg + CNT_W'(1);
                end
                if (better) begin
                    found_reg <= 1'b1;
                end
            end
            if (cmd.commit) begin
                open_reg      <= open_next;
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            w_reg     <= w_in;
            cap_reg   <= cap_in;
            mode_reg  <= cfg_mode;
            last_reg  <= s_last;
            heavy_reg <= w_in > cap_in;
        end
        if (cmd.rd_en) begin
            chk_idx_reg <= issue_reg[IDX_W-1:0];
        end
        if (better) begin
            best_idx_reg  <= chk_idx_reg;
            best_left_reg <= left;
        end
        if (cmd.commit) begin
            out_data_reg <= {res_status, n32[6:0], res_opened, idx32[5:0]};
        end
    end

    // residual room store, one read or one write a cycle
    always_ff @(posedge aclk) begin
        if (cmd.rd_en) begin
            rdata_reg <= mem[issue_reg[IDX_W-1:0]];
        end
        if (cmd.commit && wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

[sv/online_bin_packer_top.sv]
// Channel   Dir  Handshake           Payload
// s_*       in   s_tvalid/s_tready   s_tdata[15:0] item_weight, s_tlast last_item
// m_*       out  m_tvalid/m_tready   m_tdata[15:0] bin_index/opened_new/bins_in_use/status
// APB       in   psel/penable        0x0 bin_capacity, 0x4 fit_mode
//
// One item at a time. Best fit compares the item with every open bin, and
// first fit stops at the first bin with room; an item that exceeds capacity
// skips the scan. The single-port residual memory is read one bin per cycle.
// Reset is synchronous, active low; the store holds no reset and is read only
// below the bin count. The result register frees the input side: a new item
// is taken while a result waits, and the placement stalls only on a full register.
//
// Top level of the online bin packer; depends on obp_pkg, obp_ctrl, obp_dp
// and the assertion macros in online_bin_packer_top_assert.svh.
`timescale 1ns / 1ps
`include "online_bin_packer_top_assert.svh"

module online_bin_packer_top
    import obp_pkg::*;
#(
    parameter int MAX_BINS    = 64,
    parameter int WEIGHT_BITS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    // input item channel
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [15:0] item_weight
    input  logic        s_tlast,   // last_item
    // result channel
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [5:0] bin_index, [6] opened_new,
                                   // [13:7] bins_in_use, [15:14] status
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    obp_cmd_t    cmd;
    obp_sts_t    sts;
    logic [15:0] cap_reg;
    logic        mode_reg;
    logic        cfg_wr;

    // Configuration registers: bit 2 of the address picks the register,
    // the low bits are ignored so every write lands on one of the two.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg  <= CAP_RESET;
            mode_reg <= FIT_FIRST;
        end else if (cfg_wr) begin
            unique case (paddr[2])
                REG_CAP:  cap_reg  <= pwdata[15:0];
                REG_MODE: mode_reg <= pwdata[0];
                default:  ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_CAP:  prdata = {16'd0, cap_reg};
            REG_MODE: prdata = {31'd0, mode_reg};
            default:  prdata = '0;
        endcase
    end

    // Sequencer: idle, scan the open bins, commit the placement.
    obp_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // Residual store, compare and result register.
    obp_dp #(
        .MAX_BINS    (MAX_BINS),
        .WEIGHT_BITS (WEIGHT_BITS)
    ) u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .sts           (sts),
        .s_item_weight (s_tdata),
        .s_last        (s_tlast),
        .cfg_cap       (cap_reg),
        .cfg_mode      (mode_reg),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata)
    );

    // A commit must never overwrite a result that is still waiting.
    `OBP_ASSERT_NOW(a_commit_free, aclk, aresetn, cmd.commit, sts.out_free, "commit into busy result register")
    // Only one item in flight: no accept right after an accept.
    `OBP_ASSERT_NEXT(a_one_item, aclk, aresetn, s_tvalid && s_tready, !s_tready, "second item taken while busy")
    // An item that was not placed reports bin 0 and no new bin.
    `OBP_ASSERT_NOW(a_unplaced, aclk, aresetn, m_tvalid && (m_tdata[15:14] != ST_PLACED), m_tdata[6:0] == 7'd0, "unplaced item reports a bin")
    // The bin count never exceeds the number of bins.
    `OBP_ASSERT_NOW(a_count_max, aclk, aresetn, m_tvalid, (MAX_BINS > 127) || (32'(m_tdata[13:7]) <= MAX_BINS), "bin count above limit")

endmodule

[tb/tb.sv]
// Self-checking bench for online_bin_packer_top: directed rows, then random sets of items.
// Needs obp_pkg and the top level; items stream in on s_*, placements stream out on m_*.
`timescale 1ns / 1ps

module tb
    import obp_pkg::*;
();

    localparam int BIN_SLOTS = 64;

    // One placement as it travels on m_tdata, lowest field last in the list.
    typedef struct packed {
        logic [1:0] status;
        logic [6:0] in_use;
        logic       opened;
        logic [5:0] bin;
    } placement_t;

    typedef enum logic [1:0] {ROW_ITEM, ROW_CAP, ROW_MODE} row_kind_t;

    typedef struct {
        row_kind_t  kind;
        logic [15:0] value;
        logic        last;
        logic        typed;    // res holds a hand-written placement
        placement_t  res;
    } row_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata  = '0;   // [15:0] item_weight
    logic        s_tlast  = 1'b0; // last_item
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;         // [5:0] bin_index, [6] opened_new,
                                  // [13:7] bins_in_use, [15:14] status
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [2:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;
    logic [31:0] prdata;
    logic        pready;

    // Shadow of the packer: bin rooms, open count and the two registers.
    logic [15:0] room [0:BIN_SLOTS-1];
    int          bins_open  = 0;
    logic [15:0] room_cap   = CAP_RESET;
    logic        fit_policy = FIT_FIRST;

    placement_t  placements_due[$];
    int          bad_results    = 0;
    int          items_sent     = 0;
    int          results_seen   = 0;
    int          full_seen      = 0;
    int          heavy_seen     = 0;
    int          settings_used  = 1;
    logic        quiet          = 1'b0;  // no idling on either side
    int          stall_left     = 0;

    online_bin_packer_top #(
        .MAX_BINS    (BIN_SLOTS),
        .WEIGHT_BITS (16)
    ) i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // Place one item in the shadow state and return the placement it must produce.
    function automatic placement_t place_item(input logic [15:0] weight, input logic last);
        placement_t  res;
        int          pick;
        int          j;
        logic [15:0] best_left;
        res       = '0;
        pick      = -1;
        best_left = '0;
        // An over-capacity item is refused before any bin is looked at.
        if (weight > room_cap) begin
            res.status = ST_HEAVY;
        end else begin
            for (j = 0; j < bins_open; j++) begin
                if (room[j] >= weight) begin
                    // Strict less-than keeps the lowest index on a tie.
                    if (pick < 0 || room[j] - weight < best_left) begin
                        pick      = j;
                        best_left = room[j] - weight;
                    end
                    if (fit_policy == FIT_FIRST)
                        break;
                end
            end
            if (pick >= 0) begin
                room[pick] = room[pick] - weight;
                res.bin    = pick[5:0];
            end else if (bins_open < BIN_SLOTS) begin
                room[bins_open] = room_cap - weight;
                res.bin         = bins_open[5:0];
                res.opened      = 1'b1;
                bins_open++;
            end else begin
                res.status = ST_FULL;
            end
        end
        res.in_use = bins_open[6:0];
        // The count is reported first, then cleared for the next set.
        if (last)
            bins_open = 0;
        return res;
    endfunction

    task automatic note_bad(input string msg);
        if (bad_results < 10)
            $display("[%0t] %s", $realtime, msg);
        bad_results++;
    endtask

    // Present one item, hold it until taken, then queue its placement.
    task automatic send_item(input logic [15:0] weight, input logic last,
                             input logic typed, input placement_t typed_res);
        placement_t due;
        if (!quiet && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= weight;
        s_tlast  <= last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        due = place_item(weight, last);
        placements_due.push_back(typed ? typed_res : due);
        items_sent++;
    endtask

    // Drop valid and wait until every queued placement has come back.
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (placements_due.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // Setup cycle, then access cycle; the register takes the value once pready is seen.
    task automatic write_reg(input logic reg_sel, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_sel, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (reg_sel == REG_CAP)
            room_cap = value[15:0];
        else
            fit_policy = value[0];
    endtask

    // Result side: stall in random bursts, check every accepted placement in order.
    always @(posedge aclk) begin : result_check
        placement_t seen;
        placement_t want;
        if (aresetn && m_tvalid && m_tready) begin
            seen = m_tdata;
            results_seen++;
            if (placements_due.size() == 0) begin
                note_bad($sformatf("unexpected placement %h with nothing pending", m_tdata));
            end else begin
                want = placements_due.pop_front();
                if (want.status == ST_FULL)
                    full_seen++;
                if (want.status == ST_HEAVY)
                    heavy_seen++;
                if (seen.bin !== want.bin || seen.opened !== want.opened ||
                    seen.in_use !== want.in_use || seen.status !== want.status)
                    note_bad($sformatf(
                        "placement mismatch: bin %0d/%0d opened %0d/%0d in_use %0d/%0d status %0d/%0d (exp/act)",
                        want.bin, seen.bin, want.opened, seen.opened,
                        want.in_use, seen.in_use, want.status, seen.status));
            end
        end
        if (stall_left != 0) begin
            m_tready   <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (!quiet && $urandom_range(0, 9) == 0) begin
            // A burst whose length stall_left sets, counting this one.
            m_tready   <= 1'b0;
            stall_left <= $urandom_range(0, 8);
        end else begin
            m_tready <= 1'b1;
        end
    end

    initial begin : stimulus
        row_t        plan[$];
        row_t        r;
        logic [15:0] caps  [0:7];
        logic        modes [0:7];
        logic [15:0] weight;
        logic [15:0] cap;
        int          budget;
        int          set_len;
        int          k;
        int          pick;
        logic        dense;

        // Directed rows. Defaults first: capacity 100, first fit.
        plan.push_back('{ROW_ITEM, 16'd100,   1'b0, 1'b1, '{ST_PLACED, 7'd1, 1'b1, 6'd0}});
        plan.push_back('{ROW_ITEM, 16'd101,   1'b0, 1'b1, '{ST_HEAVY,  7'd1, 1'b0, 6'd0}});
        plan.push_back('{ROW_ITEM, 16'hFFFF,  1'b0, 1'b1, '{ST_HEAVY,  7'd1, 1'b0, 6'd0}});
        // Weight zero fits a bin with no room left.
        plan.push_back('{ROW_ITEM, 16'd0,     1'b0, 1'b1, '{ST_PLACED, 7'd1, 1'b0, 6'd0}});
        plan.push_back('{ROW_ITEM, 16'd30,    1'b0, 1'b1, '{ST_PLACED, 7'd2, 1'b1, 6'd1}});
        plan.push_back('{ROW_ITEM, 16'd50,    1'b0, 1'b0, '0});
        plan.push_back('{ROW_ITEM, 16'd20,    1'b1, 1'b0, '0});
        // Best fit, with a tie between two bins of equal room.
        plan.push_back('{ROW_MODE, 16'd1,     1'b0, 1'b0, '0});
        plan.push_back('{ROW_ITEM, 16'd60,    1'b0, 1'b0, '0});
        plan.push_back('{ROW_ITEM, 16'd70,    1'b0, 1'b0, '0});
        plan.push_back('{ROW_ITEM, 16'd70,    1'b0, 1'b0, '0});
        plan.push_back('{ROW_ITEM, 16'd25,    1'b0, 1'b0, '0});
        plan.push_back('{ROW_ITEM, 16'd15,    1'b0, 1'b0, '0});
        // Shrink capacity mid-set: open bins keep their room, heavy check comes first.
        plan.push_back('{ROW_CAP,  16'd10,    1'b0, 1'b0, '0});
        plan.push_back('{ROW_ITEM, 16'd50,    1'b0, 1'b1, '{ST_HEAVY,  7'd3, 1'b0, 6'd0}});
        plan.push_back('{ROW_ITEM, 16'd5,     1'b0, 1'b0, '0});
        plan.push_back('{ROW_ITEM, 16'd10,    1'b1, 1'b0, '0});
        // Zero capacity.
        plan.push_back('{ROW_CAP,  16'd0,     1'b0, 1'b0, '0});
        plan.push_back('{ROW_ITEM, 16'd0,     1'b0, 1'b1, '{ST_PLACED, 7'd1, 1'b1, 6'd0}});
        plan.push_back('{ROW_ITEM, 16'd1,     1'b0, 1'b1, '{ST_HEAVY,  7'd1, 1'b0, 6'd0}});
        plan.push_back('{ROW_ITEM, 16'd0,     1'b1, 1'b0, '0});
        // Largest capacity and weight.
        plan.push_back('{ROW_CAP,  16'hFFFF,  1'b0, 1'b0, '0});
        plan.push_back('{ROW_ITEM, 16'hFFFF,  1'b0, 1'b1, '{ST_PLACED, 7'd1, 1'b1, 6'd0}});
        plan.push_back('{ROW_ITEM, 16'hFFFF,  1'b1, 1'b1, '{ST_PLACED, 7'd2, 1'b1, 6'd1}});

        // Random phases: small, largest and typical capacities under both policies.
        caps[0] = 16'd1;     modes[0] = 1'b0;
        caps[1] = 16'd1;     modes[1] = 1'b1;
        caps[2] = 16'hFFFF;  modes[2] = 1'b0;
        caps[3] = 16'hFFFF;  modes[3] = 1'b1;
        caps[4] = 16'd100;   modes[4] = 1'b1;
        caps[5] = 16'd100;   modes[5] = 1'b0;
        caps[6] = 16'($urandom_range(2, 300));   modes[6] = 1'($urandom_range(0, 1));
        caps[7] = 16'($urandom_range(1, 65535)); modes[7] = 1'($urandom_range(0, 1));

        // Hold reset once, at the start.
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (plan[i]) begin
            r = plan[i];
            case (r.kind)
                ROW_ITEM: begin
                    send_item(r.value, r.last, r.typed, r.res);
                end
                ROW_CAP: begin
                    drain();
                    write_reg(REG_CAP, {16'h0, r.value});
                    settings_used++;
                end
                default: begin
                    drain();
                    write_reg(REG_MODE, {31'h0, r.value[0]});
                    settings_used++;
                end
            endcase
        end

        for (int ph = 0; ph < 8; ph++) begin
            drain();
            // Junk in the unused upper bits must be ignored.
            write_reg(REG_CAP, ($urandom & 32'hFFFF_0000) | {16'h0, caps[ph]});
            write_reg(REG_MODE, ($urandom & 32'hFFFF_FFFE) | {31'h0, modes[ph]});
            settings_used++;
            cap = caps[ph];
            // Run the last phase with no idling on either side.
            quiet  = (ph == 7);
            budget = 85;
            while (budget > 0) begin
                // Long dense sets push the bin count up to the limit.
                dense   = ($urandom_range(0, 9) < 3);
                set_len = dense ? $urandom_range(60, 72) : $urandom_range(1, 20);
                if (set_len > budget)
                    set_len = budget;
                for (k = 0; k < set_len; k++) begin
                    pick = $urandom_range(0, 19);
                    if (pick == 0)
                        weight = '0;
                    else if (pick == 1)
                        weight = cap;
                    else if (pick == 2)
                        weight = (cap == 16'hFFFF) ? 16'($urandom)
                                                   : 16'($urandom_range(cap + 1, 65535));
                    else if (pick < 7)
                        weight = 16'($urandom_range(0, cap));
                    else if (dense || pick < 13)
                        weight = 16'($urandom_range((cap + 1) / 2, cap));
                    else
                        weight = 16'($urandom_range(0, cap / 4));
                    // Now and then leave the set open so it runs on into the next one.
                    send_item(weight, (k == set_len - 1) && ($urandom_range(0, 9) != 0),
                              1'b0, '0);
                end
                budget -= set_len;
            end
        end

        // Wait out the last placements, then give stray results a chance to show.
        s_tvalid <= 1'b0;
        while (placements_due.size() != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);

        $display("Sent %0d items under %0d register settings; checked %0d placements,",
                 items_sent, settings_used, results_seen);
        $display("among them %0d with every bin full and %0d over capacity.",
                 full_seen, heavy_seen);
        if (bad_results == 0) begin
            $display("end of test: clean");
        end else begin
            $display("%0d bad placements", bad_results);
            $display("end of test: mismatches");
        end
        $finish;
    end

    // Guard against a hung handshake.
    initial begin : watchdog
        #10ms;
        $display("timeout with %0d placements pending", placements_due.size());
        $display("end of test: mismatches");
        $finish;
    end

endmodule
